// ===== design/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache unit.
package salc_pkg;
    localparam int MaxSetBits = 8;
    localparam int MaxWays    = 8;
    localparam int NumSets    = 1 << MaxSetBits;
    localparam int WayW       = $clog2(MaxWays);
    localparam int SetW       = MaxSetBits;
    localparam int RankRowW   = MaxWays * WayW;

    localparam logic [1:0] OpLoad   = 2'd0;
    localparam logic [1:0] OpStore  = 2'd1;
    localparam logic [1:0] OpModify = 2'd2;
    localparam logic [1:0] OpIfetch = 2'd3;

    localparam logic [1:0] CfgSetBits   = 2'd0;
    localparam logic [1:0] CfgBlockBits = 2'd1;
    localparam logic [1:0] CfgWaysUsed  = 2'd2;

    typedef struct packed {
        logic start;     // look up the request just latched
        logic update;    // write back the set and counters
        logic out_take;  // result register consumed
    } salc_cmd_t;

    typedef struct packed {
        logic clearing;  // reset sweep of the rank and valid memories in progress
    } salc_sts_t;
endpackage

// ===== design/salc_datapath.sv =====
// Datapath: set memories, tag compare, LRU victim choice, counters, result register.
module salc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          opcode,
    input  logic [63:0]         address,
    input  logic                req_load,
    input  logic [3:0]          set_bits,
    input  logic [5:0]          block_bits,
    input  logic [3:0]          ways_used,
    input  salc_pkg::salc_cmd_t cmd,
    output salc_pkg::salc_sts_t sts,
    output logic [103:0]        result
);
    import salc_pkg::*;

    logic [1:0]         op_reg;
    logic [63:0]        addr_reg;
    logic [SetW-1:0]    set_reg;
    logic [63:0]        tag_reg;
    logic [MaxWays-1:0] valid_mem [NumSets];
    logic [63:0]        tag_mem [NumSets][MaxWays];
    logic [RankRowW-1:0] rank_mem [NumSets];
    logic [63:0]        tag_rd [MaxWays];
    logic [MaxWays-1:0] vrow_reg;
    logic [RankRowW-1:0] rrow_reg;
    logic [31:0]        hits_reg, misses_reg, evicts_reg;
    logic [SetW:0]      clr_reg;
    logic [103:0]       result_reg;

    logic [3:0]  s_eff;
    logic [3:0]  ways_eff;
    logic [6:0]  shift;
    logic [63:0] set_full;
    logic [63:0] tag_c;

    always_comb
    begin
        s_eff    = (set_bits > 4'(MaxSetBits)) ? 4'(MaxSetBits) : set_bits;
        ways_eff = (ways_used == 4'd0) ? 4'd1
                 : ((ways_used > 4'(MaxWays)) ? 4'(MaxWays) : ways_used);
        set_full = (addr_reg >> block_bits) & ((64'd1 << s_eff) - 64'd1);
        shift    = 7'(s_eff) + 7'(block_bits);
        tag_c    = (shift >= 7'd64) ? 64'd0 : (addr_reg >> shift);
    end

    // second phase: decide using registered set contents
    logic               found, free_found;
    logic [WayW-1:0]    hit_way, free_way, lru_way, way;
    logic [WayW-1:0]    best;
    logic [WayW-1:0]    old_rank;
    logic               hit, miss, evict;
    logic [RankRowW-1:0] rrow_new;
    logic [WayW-1:0]    rk;

    always_comb
    begin
        found = 1'b0; free_found = 1'b0;
        hit_way = '0; free_way = '0; lru_way = '0; best = '0;
        for (int w = MaxWays - 1; w >= 0; w--)
        begin
            if (4'(w) < ways_eff)
            begin
                if (vrow_reg[w] && tag_rd[w] == tag_reg)
                begin
                    found = 1'b1; hit_way = WayW'(w);
                end
                if (!vrow_reg[w])
                begin
                    free_found = 1'b1; free_way = WayW'(w);
                end
            end
        end
        for (int w = 0; w < MaxWays; w++)
        begin
            if (4'(w) < ways_eff && rrow_reg[w*WayW +: WayW] >= best)
            begin
                best = rrow_reg[w*WayW +: WayW]; lru_way = WayW'(w);
            end
        end
        hit   = found;
        miss  = !found;
        evict = !found && !free_found;
        way   = found ? hit_way : (free_found ? free_way : lru_way);
        old_rank = rrow_reg[way*WayW +: WayW];
        rrow_new = rrow_reg;
        for (int k = 0; k < MaxWays; k++)
        begin
            rk = rrow_reg[k*WayW +: WayW];
            if (rk < old_rank)
                rrow_new[k*WayW +: WayW] = rk + WayW'(1);
        end
        rrow_new[way*WayW +: WayW] = '0;
    end

    logic [RankRowW-1:0] init_row;
    always_comb
    begin
        for (int k = 0; k < MaxWays; k++)
            init_row[k*WayW +: WayW] = WayW'(k);
    end

    assign sts.clearing = !clr_reg[SetW];

    always_ff @(posedge clk)
    begin
        if (req_load)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
        end
        if (cmd.start)
        begin
            set_reg  <= set_full[SetW-1:0];
            tag_reg  <= tag_c;
            rrow_reg <= rank_mem[set_full[SetW-1:0]];
            vrow_reg <= valid_mem[set_full[SetW-1:0]];
            for (int w = 0; w < MaxWays; w++)
                tag_rd[w] <= tag_mem[set_full[SetW-1:0]][w];
        end
        if (!clr_reg[SetW])
        begin
            rank_mem[clr_reg[SetW-1:0]]  <= init_row;
            valid_mem[clr_reg[SetW-1:0]] <= '0;
        end
        else if (cmd.update)
        begin
            rank_mem[set_reg] <= rrow_new;
            if (miss)
            begin
                tag_mem[set_reg][way]   <= tag_reg;
                valid_mem[set_reg][way] <= 1'b1;
            end
        end
    end

    logic [31:0] hits_next;
    assign hits_next = hits_reg + 32'(hit) + 32'(op_reg == OpModify);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
            clr_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            if (!clr_reg[SetW])
                clr_reg <= clr_reg + 1'b1;
            if (cmd.update)
            begin
                hits_reg   <= hits_next;
                misses_reg <= misses_reg + 32'(miss);
                evicts_reg <= evicts_reg + 32'(evict);
                result_reg <= {evicts_reg + 32'(evict), misses_reg + 32'(miss),
                               hits_next, 5'd0, evict, miss, hit};
            end
        end
    end

    assign result = result_reg;
endmodule

// ===== design/salc_ctrl.sv =====
// Controller: request handshake, lookup and update sequencing, result handshake.
module salc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [1:0]          opcode,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic                req_load,
    output salc_pkg::salc_cmd_t cmd,
    input  salc_pkg::salc_sts_t sts
);
    import salc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD} state_t;
    state_t state_reg;
    logic   ovalid_reg;

    assign s_axis_tready = (state_reg == S_IDLE) && !sts.clearing;
    assign req_load      = s_axis_tready && s_axis_tvalid && opcode != OpIfetch;
    assign m_axis_tvalid = ovalid_reg;
    assign cmd.start     = (state_reg == S_LOOK);
    assign cmd.update    = (state_reg == S_UPD) && (!ovalid_reg || m_axis_tready);
    assign cmd.out_take  = ovalid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
                ovalid_reg <= 1'b1;
            else if (cmd.out_take)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:  if (req_load) state_reg <= S_LOOK;
                S_LOOK:  state_reg <= S_UPD;
                S_UPD:   if (cmd.update) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/set_assoc_lru_cache_sim_unit.sv =====
// Top level of the set-associative LRU cache simulation unit.
// Each request passes through the lookup state (set row read) and the update state (decision,
// write-back and result register); a new request is accepted only in idle.
// The result register lets the next request start while a result waits.
// Reset: async active low; a sweep over all 256 sets loads LRU ranks and clears valid bits,
// tready low meanwhile.
module set_assoc_lru_cache_sim_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // opcode[1:0], address[65:2], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [103:0] m_axis_tdata,  // hit, miss, evict, 5 zeros, hits, misses, evictions
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import salc_pkg::*;

    logic [3:0] set_bits_reg, ways_reg;
    logic [5:0] block_bits_reg;
    logic       req_load;
    salc_cmd_t  cmd;
    salc_sts_t  sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 4'd4;
            block_bits_reg <= 6'd4;
            ways_reg       <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgSetBits:   set_bits_reg   <= cfg_data[3:0];
                CfgBlockBits: block_bits_reg <= cfg_data;
                CfgWaysUsed:  ways_reg       <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    salc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .opcode(s_axis_tdata[1:0]),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .req_load(req_load), .cmd(cmd), .sts(sts)
    );

    salc_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .opcode(s_axis_tdata[1:0]), .address(s_axis_tdata[65:2]),
        .req_load(req_load),
        .set_bits(set_bits_reg), .block_bits(block_bits_reg), .ways_used(ways_reg),
        .cmd(cmd), .sts(sts), .result(m_axis_tdata)
    );
endmodule

// ===== tb/sv/tb_set_assoc_lru_cache_sim_unit.sv =====
// Testbench for the set-associative LRU cache unit: directed and random requests against a predictor.
module tb_set_assoc_lru_cache_sim_unit;
    import salc_pkg::*;

    localparam logic [1:0] CfgUnused = 2'd3;
    localparam int NumLines = NumSets * MaxWays;

    typedef struct {
        logic        hit;
        logic        miss;
        logic        evict;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } lookup_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [5:0]   cfg_data;

    set_assoc_lru_cache_sim_unit dut (.*);

    // predictor state
    logic [3:0]  set_bits_q;
    logic [5:0]  block_bits_q;
    logic [3:0]  ways_q;
    logic        line_ok[NumLines];
    logic [63:0] line_tag[NumLines];
    int          line_rank[NumLines];
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;

    lookup_t lookups_due[$];
    int      err_count;
    int      result_count;
    int      request_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 800000);
        $display("tb_set_assoc_lru_cache_sim_unit: done, errors");
        $finish;
    end

    function automatic void model_reset();
        set_bits_q   = 4'd4;
        block_bits_q = 6'd4;
        ways_q       = 4'd1;
        for (int i = 0; i < NumLines; i++)
        begin
            line_ok[i]   = 1'b0;
            line_tag[i]  = '0;
            line_rank[i] = i % MaxWays;
        end
        hit_total   = '0;
        miss_total  = '0;
        evict_total = '0;
    endfunction

    function automatic int eff_set_bits();
        return (set_bits_q > MaxSetBits) ? MaxSetBits : set_bits_q;
    endfunction

    function automatic int eff_ways();
        if (ways_q == 0)
            return 1;
        return (ways_q > MaxWays) ? MaxWays : ways_q;
    endfunction

    function automatic void predict_lookup(logic [1:0] op, logic [63:0] addr);
        int      s;
        int      ways;
        int      shift;
        int      base;
        int      way;
        int      best;
        int      old;
        bit      found;
        logic [63:0] tg;
        lookup_t r;
        if (op == OpIfetch)
            return;
        s     = eff_set_bits();
        ways  = eff_ways();
        shift = s + block_bits_q;
        tg    = (shift >= 64) ? 64'd0 : (addr >> shift);
        base  = int'((addr >> block_bits_q) & ((64'd1 << s) - 1)) * MaxWays;
        found = 0;
        way   = 0;
        r     = '{default: '0};
        for (int w = 0; w < ways && !found; w++)
            if (line_ok[base + w] && line_tag[base + w] == tg)
            begin
                found = 1;
                way   = w;
            end
        if (found)
        begin
            r.hit = 1'b1;
            hit_total++;
        end
        else
        begin
            r.miss = 1'b1;
            miss_total++;
            for (int w = 0; w < ways && !found; w++)
                if (!line_ok[base + w])
                begin
                    found = 1;
                    way   = w;
                end
            if (!found)
            begin
                r.evict = 1'b1;
                evict_total++;
                best = 0;
                for (int w = 0; w < ways; w++)
                    if (line_rank[base + w] >= best)
                    begin
                        best = line_rank[base + w];
                        way  = w;
                    end
            end
            line_ok[base + way]  = 1'b1;
            line_tag[base + way] = tg;
        end
        old = line_rank[base + way];
        for (int k = 0; k < MaxWays; k++)
            if (line_rank[base + k] < old)
                line_rank[base + k]++;
        line_rank[base + way] = 0;
        if (op == OpModify)
            hit_total++;
        r.hits      = hit_total;
        r.misses    = miss_total;
        r.evictions = evict_total;
        lookups_due.push_back(r);
    endfunction

    task automatic send_request(logic [1:0] op, logic [63:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, addr, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_lookup(op, addr);
        request_count++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (lookups_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [5:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CfgSetBits:   set_bits_q   = val[3:0];
            CfgBlockBits: block_bits_q = val;
            CfgWaysUsed:  ways_q       = val[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // mostly reuses a few tags per set so hits and evictions are common
    function automatic logic [63:0] pick_addr();
        int          shift;
        logic [63:0] a;
        if ($urandom_range(9) == 0)
            return {$urandom(), $urandom()};
        shift = eff_set_bits() + block_bits_q;
        a = {$urandom(), $urandom()} & ((64'd1 << block_bits_q) - 1);
        a |= (64'($urandom_range(3)) << block_bits_q);
        if (shift < 64)
            a |= (64'($urandom_range(eff_ways() + 2)) << shift);
        return a;
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return OpLoad;
        if (r < 7)
            return OpStore;
        if (r < 9)
            return OpModify;
        return OpIfetch;
    endfunction

    task automatic test_directed();
        send_request(OpLoad, 64'd0);
        send_request(OpLoad, 64'd0);
        send_request(OpStore, 64'd0);
        send_request(OpModify, 64'd0);
        send_request(OpIfetch, 64'd0);
        send_request(OpLoad, '1);
        send_request(OpModify, '1);
        send_request(OpIfetch, '1);
        send_request(OpLoad, 64'h100);
        send_request(OpLoad, 64'h0);
        write_cfg(CfgWaysUsed, 6'd0);
        send_request(OpStore, 64'h200);
        write_cfg(CfgWaysUsed, 6'd15);
        write_cfg(CfgSetBits, 6'd15);
        send_request(OpLoad, 64'h1000);
        send_request(OpLoad, 64'h2000);
        write_cfg(CfgBlockBits, 6'd63);
        send_request(OpLoad, '1);
        send_request(OpLoad, 64'h8000_0000_0000_0000);
        send_request(OpModify, 64'h0);
        write_cfg(CfgUnused, 6'd63);
        write_cfg(CfgBlockBits, 6'd0);
        write_cfg(CfgSetBits, 6'd0);
        send_request(OpLoad, 64'h5);
        send_request(OpLoad, 64'h5);
        wait_drained();
    endtask

    task automatic test_random_configs();
        logic [5:0] sb[6] = '{6'd4, 6'd0, 6'd8, 6'd2, 6'd12, 6'd3};
        logic [5:0] bb[6] = '{6'd4, 6'd0, 6'd32, 6'd6, 6'd63, 6'd1};
        logic [5:0] wy[6] = '{6'd1, 6'd8, 6'd4, 6'd2, 6'd1, 6'd9};
        for (int m = 0; m < 3; m++)
        begin
            send_idle_pct = (m == 0) ? 30 : (m == 1) ? 67 : 0;
            recv_idle_pct = (m == 0) ? 67 : (m == 1) ? 30 : 0;
            for (int c = 0; c < 6; c++)
            begin
                write_cfg(CfgSetBits, sb[c]);
                write_cfg(CfgBlockBits, bb[c]);
                write_cfg(CfgWaysUsed, wy[c]);
                repeat (100) send_request(pick_op(), pick_addr());
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(CfgSetBits, 6'd1);
        write_cfg(CfgBlockBits, 6'd2);
        write_cfg(CfgWaysUsed, 6'd2);
        stall_cycles = 300;
        repeat (60) send_request(pick_op(), pick_addr());
        wait_drained();
    endtask

    // receiver ready, with a long hold-off when requested
    always @(posedge clk)
    begin
        if (stall_cycles > 0)
        begin
            stall_cycles  <= stall_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (lookups_due.size() == 0)
            begin
                $error("unexpected result %h", m_axis_tdata);
                err_count++;
            end
            else
            begin
                e = lookups_due.pop_front();
                if (m_axis_tdata[0] !== e.hit)
                begin
                    $error("access_hit exp %0d got %0d", e.hit, m_axis_tdata[0]);
                    err_count++;
                end
                if (m_axis_tdata[1] !== e.miss)
                begin
                    $error("access_miss exp %0d got %0d", e.miss, m_axis_tdata[1]);
                    err_count++;
                end
                if (m_axis_tdata[2] !== e.evict)
                begin
                    $error("access_evict exp %0d got %0d", e.evict, m_axis_tdata[2]);
                    err_count++;
                end
                if (m_axis_tdata[39:8] !== e.hits)
                begin
                    $error("hit_count exp %0d got %0d", e.hits, m_axis_tdata[39:8]);
                    err_count++;
                end
                if (m_axis_tdata[71:40] !== e.misses)
                begin
                    $error("miss_count exp %0d got %0d", e.misses, m_axis_tdata[71:40]);
                    err_count++;
                end
                if (m_axis_tdata[103:72] !== e.evictions)
                begin
                    $error("eviction_count exp %0d got %0d", e.evictions,
                           m_axis_tdata[103:72]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        err_count     = 0;
        result_count  = 0;
        request_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_cycles  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CfgSetBits;
        cfg_data      = '0;
        model_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_configs();
        test_backpressure();
        $display("requests sent: %0d, results checked: %0d", request_count, result_count);
        $display("covered all ops, config extremes, way/set/block sweeps, long output stall");
        if (err_count == 0)
            $display("tb_set_assoc_lru_cache_sim_unit: done, clean");
        else
            $display("tb_set_assoc_lru_cache_sim_unit: done, errors");
        $finish;
    end
endmodule
